### sv/vasl_pkg.sv
// Shared types, constants and helpers of the view angle soft limit and lock block.
package vasl_pkg;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RM0,
        S_RM_DIV,
        S_RM_M1,
        S_RM_M2,
        S_RM_M3,
        S_RM_FIN,
        S_W0,
        S_W1,
        S_W2,
        S_LM,
        S_LR,
        S_LK0,
        S_LKD,
        S_DONE
    } t_state;

    // Band of one axis magnitude.
    typedef enum logic [1:0] {
        BAND_ZERO,
        BAND_SPLINE,
        BAND_LINEAR
    } t_band;

    // What a finished blend feeds.
    typedef enum logic {
        PH_FADE,
        PH_LOCK
    } t_phase;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PITCH_DEAD   = 3'd0;
    localparam logic [2:0] CFG_PITCH_LIN    = 3'd1;
    localparam logic [2:0] CFG_ROLL_DEAD    = 3'd2;
    localparam logic [2:0] CFG_ROLL_LIN     = 3'd3;
    localparam logic [2:0] CFG_PITCH_HOLD   = 3'd4;
    localparam logic [2:0] CFG_PITCH_BLEND  = 3'd5;
    localparam logic [2:0] CFG_ROLL_HOLD    = 3'd6;
    localparam logic [2:0] CFG_ROLL_BLEND   = 3'd7;

    // Divider geometry: the quotient never exceeds one in Q16.
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_Q_W   = 17;

    // Arithmetic constants.
    localparam logic [16:0] Q_ONE        = 17'd65536;
    localparam logic [17:0] SPLINE_K3    = 18'd196608;
    localparam logic [23:0] DEG80_SCALED = 24'd5242880;
    localparam logic [17:0] DEG_FACTOR   = 18'd360;
    localparam logic [23:0] DEG_ROUND    = 24'd10;
    localparam logic [23:0] ROLL_W_SAT   = 24'd1310720;
    localparam logic [15:0] DEG60_MAG    = 16'd10922;

    // One twentieth in Q24, rounded up; exact for numerators below 2^22.
    localparam logic [19:0] DEG_STEP_RECIP = 20'd838861;

    // Magnitude of a 16-bit signed angle; the most negative value maps to 32768.
    function automatic logic [15:0] abs16(input logic [15:0] x);
        abs16 = x[15] ? (~x + 16'd1) : x;
    endfunction

endpackage

### sv/view_angle_soft_limit_lock_unit.sv
// View angle soft limit and lock: top level with sequencer and shared datapath.
//
// Input channel: i_valid with o_stall carries raw pitch, roll and a time stamp.
// A request is taken when i_valid is high and o_stall is low. Output channel:
// o_valid with i_stall carries conditioned pitch and roll and the two lock flags.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// idle; the user must keep to this, as the block itself does not enforce it.
//
// One request at a time runs through a small sequencer that reuses a single
// multiplier and a 17-step restoring divider. The divider is used up to four
// times per request (two spline parameters and two unlock weights); the roll
// fade weight divides by a constant through a reciprocal multiply.
// o_stall is high from acceptance until the result moves into the output
// register. A finished result waits in its own state while the output register
// is still held by a stalled receiver; the output register keeps its contents
// until taken. Reset clears the lock state, loads register defaults and
// leaves the output empty.
module view_angle_soft_limit_lock_unit
    import vasl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_pitch_in,
    input  logic signed [15:0] i_roll_in,
    input  logic [31:0]        i_time_now,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pitch_out,
    output logic signed [15:0] o_roll_out,
    output logic               o_pitch_is_locked,
    output logic               o_roll_is_locked,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_cfg_pdead, r_cfg_plin, r_cfg_rdead, r_cfg_rlin;
    logic [23:0] r_cfg_phold, r_cfg_pblend, r_cfg_rhold, r_cfg_rblend;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic               r_ax, n_ax;
    t_phase             r_phase, n_phase;
    logic signed [15:0] r_pin, n_pin, r_rin, n_rin;
    logic [31:0]        r_now, n_now;
    logic signed [15:0] r_pmap, n_pmap, r_rdamp, n_rdamp, r_rmap, n_rmap;
    logic signed [15:0] r_pout, n_pout, r_rout, n_rout;
    t_band              r_pband, n_pband, r_rband, n_rband;
    logic [16:0]        r_t, n_t, r_w, n_w;
    logic signed [15:0] r_la, n_la, r_lb, n_lb;
    logic [50:0]        r_prod;
    logic [1:0]         r_lock, n_lock, r_blend, n_blend;
    logic [31:0]        r_mark [2];
    logic [31:0]        n_mark [2];
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_opitch, n_opitch, r_oroll, n_oroll;
    logic               r_oplock, n_oplock, r_orlock, n_orlock;

    // Shared units.
    logic [32:0]          m_a;
    logic [19:0]          m_b;
    logic                 d_start, d_done;
    logic [DIV_NUM_W-1:0] d_num;
    logic [DIV_DEN_W-1:0] d_den;
    logic [DIV_Q_W-1:0]   d_quo;

    vasl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_quo   (d_quo)
    );

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pdead  <= 16'd0;
            r_cfg_plin   <= 16'd32768;
            r_cfg_rdead  <= 16'd0;
            r_cfg_rlin   <= 16'd32768;
            r_cfg_phold  <= 24'd0;
            r_cfg_pblend <= 24'd0;
            r_cfg_rhold  <= 24'd0;
            r_cfg_rblend <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PITCH_DEAD:  r_cfg_pdead  <= i_cfg_data[15:0];
                CFG_PITCH_LIN:   r_cfg_plin   <= i_cfg_data[15:0];
                CFG_ROLL_DEAD:   r_cfg_rdead  <= i_cfg_data[15:0];
                CFG_ROLL_LIN:    r_cfg_rlin   <= i_cfg_data[15:0];
                CFG_PITCH_HOLD:  r_cfg_phold  <= i_cfg_data;
                CFG_PITCH_BLEND: r_cfg_pblend <= i_cfg_data;
                CFG_ROLL_HOLD:   r_cfg_rhold  <= i_cfg_data;
                CFG_ROLL_BLEND:  r_cfg_rblend <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        r_prod <= 51'(m_a) * 51'(m_b);
    end

    // Next state, datapath updates and shared unit control.
    always_comb begin
        logic signed [15:0] v;
        logic [15:0]        a, dead, lin;
        logic               rm_done;
        logic signed [15:0] rm_val;
        t_band              rm_band;
        logic [32:0]        mag_sum;
        logic [16:0]        mag;
        logic               fade_go;
        logic [16:0]        fade_w;
        logic [23:0]        w_num;
        logic signed [16:0] ldiff;
        logic [16:0]        ldiff_mag;
        logic [33:0]        rnd_sum;
        logic [17:0]        r_off;
        logic signed [17:0] lsum;
        logic signed [15:0] lres;
        logic               ax_done;
        logic signed [15:0] ax_val;
        logic [23:0]        hold, blen;
        t_band              band;
        logic signed [15:0] raw, mapped;
        logic               lk, bl;
        logic [31:0]        mk, dlt, el;

        n_state  = r_state;
        n_ax     = r_ax;
        n_phase  = r_phase;
        n_pin    = r_pin;
        n_rin    = r_rin;
        n_now    = r_now;
        n_pmap   = r_pmap;
        n_rdamp  = r_rdamp;
        n_rmap   = r_rmap;
        n_pout   = r_pout;
        n_rout   = r_rout;
        n_pband  = r_pband;
        n_rband  = r_rband;
        n_t      = r_t;
        n_w      = r_w;
        n_la     = r_la;
        n_lb     = r_lb;
        n_lock   = r_lock;
        n_blend  = r_blend;
        n_mark   = r_mark;
        n_ovalid = r_ovalid && i_stall;
        n_opitch = r_opitch;
        n_oroll  = r_oroll;
        n_oplock = r_oplock;
        n_orlock = r_orlock;
        m_a      = '0;
        m_b      = '0;
        d_start  = 1'b0;
        d_num    = '0;
        d_den    = '0;
        rm_done  = 1'b0;
        rm_val   = '0;
        rm_band  = BAND_ZERO;
        fade_go  = 1'b0;
        fade_w   = Q_ONE;
        ax_done  = 1'b0;
        ax_val   = '0;
        w_num    = '0;

        // Per-axis selections.
        v      = r_ax ? r_rin : r_pin;
        a      = abs16(v);
        dead   = r_ax ? r_cfg_rdead : r_cfg_pdead;
        lin    = r_ax ? r_cfg_rlin : r_cfg_plin;
        hold   = r_ax ? r_cfg_rhold : r_cfg_phold;
        blen   = r_ax ? r_cfg_rblend : r_cfg_pblend;
        band   = r_ax ? r_rband : r_pband;
        raw    = r_ax ? r_rin : r_pin;
        mapped = r_ax ? r_rmap : r_pmap;
        lk     = r_lock[r_ax];
        bl     = r_blend[r_ax];
        mk     = r_mark[r_ax];
        dlt    = r_now - mk;
        el     = '0;

        // Spline magnitude rounding.
        mag_sum = r_prod[32:0] + 33'd32768;
        mag     = mag_sum[32:16];

        // Blend arithmetic.
        ldiff     = 17'({r_lb[15], r_lb}) - 17'({r_la[15], r_la});
        ldiff_mag = ldiff[16] ? 17'(-ldiff) : 17'(ldiff);
        rnd_sum   = r_prod[33:0] + 34'd32768;
        r_off     = rnd_sum[33:16];
        lsum      = ldiff[16] ? (18'({r_la[15], r_la[15], r_la}) - 18'(r_off))
                              : (18'({r_la[15], r_la[15], r_la}) + 18'(r_off));
        lres      = lsum[15:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pin   = i_pitch_in;
                    n_rin   = i_roll_in;
                    n_now   = i_time_now;
                    n_ax    = 1'b0;
                    n_state = S_RM0;
                end
            end

            // Classify the magnitude and start the spline parameter division.
            S_RM0: begin
                if (a < dead) begin
                    rm_band = BAND_ZERO;
                    rm_done = 1'b1;
                    rm_val  = '0;
                end else if (a <= lin) begin
                    rm_band = BAND_SPLINE;
                    if (lin == dead) begin
                        rm_done = 1'b1;
                        rm_val  = v;
                    end else begin
                        d_start = 1'b1;
                        d_num   = DIV_NUM_W'({16'(a - dead), 16'd0});
                        d_den   = DIV_DEN_W'(16'(lin - dead));
                        n_state = S_RM_DIV;
                    end
                end else begin
                    rm_band = BAND_LINEAR;
                    rm_done = 1'b1;
                    rm_val  = v;
                end
                if (r_ax) begin
                    n_rband = rm_band;
                end else begin
                    n_pband = rm_band;
                end
            end

            S_RM_DIV: begin
                if (d_done) begin
                    n_t     = d_quo;
                    n_state = S_RM_M1;
                end
            end

            // Smoothstep: t*t, then times (3 - 2t), then scale by the linear start.
            S_RM_M1: begin
                m_a     = 33'(r_t);
                m_b     = 20'(r_t);
                n_state = S_RM_M2;
            end

            S_RM_M2: begin
                m_a     = r_prod[32:0];
                m_b     = 20'(SPLINE_K3 - {r_t, 1'b0});
                n_state = S_RM_M3;
            end

            S_RM_M3: begin
                m_a     = 33'(r_prod[48:32]);
                m_b     = 20'(lin);
                n_state = S_RM_FIN;
            end

            // Round, apply the sign and saturate.
            S_RM_FIN: begin
                rm_done = 1'b1;
                if (v[15]) begin
                    rm_val = (mag > 17'd32768) ? 16'sh8000 : 16'(-mag);
                end else begin
                    rm_val = (mag > 17'd32767) ? 16'sh7fff : 16'(mag);
                end
            end

            // Roll fade weight from the remapped pitch magnitude.
            S_W0: begin
                if (abs16(r_pin) > DEG60_MAG) begin
                    m_a     = 33'(abs16(r_pmap));
                    m_b     = 20'(DEG_FACTOR);
                    n_state = S_W1;
                end else begin
                    fade_go = 1'b1;
                    fade_w  = Q_ONE;
                end
            end

            // Divide the rounded numerator by 20 with a reciprocal multiply.
            S_W1: begin
                w_num = DEG80_SCALED - r_prod[23:0] + DEG_ROUND;
                if (r_prod[23:0] >= DEG80_SCALED) begin
                    fade_go = 1'b1;
                    fade_w  = '0;
                end else if (w_num >= ROLL_W_SAT) begin
                    fade_go = 1'b1;
                    fade_w  = Q_ONE;
                end else begin
                    m_a     = 33'(w_num);
                    m_b     = DEG_STEP_RECIP;
                    n_state = S_W2;
                end
            end

            S_W2: begin
                fade_go = 1'b1;
                fade_w  = r_prod[40:24];
            end

            // Blend: product of the difference magnitude and the weight.
            S_LM: begin
                m_a     = 33'(ldiff_mag);
                m_b     = 20'(r_w);
                n_state = S_LR;
            end

            S_LR: begin
                case (r_phase)
                    PH_FADE: begin
                        n_rmap  = lres;
                        n_ax    = 1'b0;
                        n_state = S_LK0;
                    end
                    PH_LOCK: begin
                        ax_done = 1'b1;
                        ax_val  = lres;
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            // Lock update for the selected axis.
            S_LK0: begin
                if (hold == '0) begin
                    ax_done = 1'b1;
                    ax_val  = mapped;
                end else if (band == BAND_LINEAR || (lk && band == BAND_SPLINE)) begin
                    n_lock[r_ax]  = 1'b1;
                    n_blend[r_ax] = 1'b0;
                    n_mark[r_ax]  = r_now + 32'(hold);
                    ax_done       = 1'b1;
                    ax_val        = raw;
                end else begin
                    // The hold deadline has passed: unlock, and start the fade if a blend time is set.
                    if (lk && dlt != '0 && !dlt[31]) begin
                        lk = 1'b0;
                        bl = (blen != '0);
                        mk = r_now;
                    end
                    el            = r_now - mk;
                    n_lock[r_ax]  = lk;
                    n_blend[r_ax] = bl;
                    n_mark[r_ax]  = mk;
                    n_la          = raw;
                    n_lb          = mapped;
                    n_phase       = PH_LOCK;
                    if (lk) begin
                        ax_done = 1'b1;
                        ax_val  = raw;
                    end else if (bl) begin
                        if (blen == '0 || el >= 32'(blen)) begin
                            n_blend[r_ax] = 1'b0;
                            n_w           = Q_ONE;
                            n_state       = S_LM;
                        end else begin
                            d_start = 1'b1;
                            d_num   = DIV_NUM_W'({el[23:0], 16'd0});
                            d_den   = blen;
                            n_state = S_LKD;
                        end
                    end else begin
                        ax_done = 1'b1;
                        ax_val  = mapped;
                    end
                end
            end

            S_LKD: begin
                if (d_done) begin
                    n_w     = d_quo;
                    n_state = S_LM;
                end
            end

            // Move the result into the output register once it is free.
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_opitch = r_pout;
                    n_oroll  = r_rout;
                    n_oplock = r_lock[0];
                    n_orlock = r_lock[1];
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Remap finished for one axis.
        if (rm_done) begin
            if (r_ax) begin
                n_rdamp = rm_val;
                n_ax    = 1'b0;
                n_state = S_W0;
            end else begin
                n_pmap  = rm_val;
                n_ax    = 1'b1;
                n_state = S_RM0;
            end
        end

        // Roll fade weight known: blend raw roll toward the remapped roll.
        if (fade_go) begin
            n_w     = fade_w;
            n_la    = r_rin;
            n_lb    = r_rdamp;
            n_phase = PH_FADE;
            n_state = S_LM;
        end

        // Lock finished for one axis.
        if (ax_done) begin
            if (r_ax) begin
                n_rout  = ax_val;
                n_state = S_DONE;
            end else begin
                n_pout  = ax_val;
                n_ax    = 1'b1;
                n_state = S_LK0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_lock    <= '0;
            r_blend   <= '0;
            r_mark[0] <= '0;
            r_mark[1] <= '0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_lock    <= n_lock;
            r_blend   <= n_blend;
            r_mark[0] <= n_mark[0];
            r_mark[1] <= n_mark[1];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_phase  <= n_phase;
        r_pin    <= n_pin;
        r_rin    <= n_rin;
        r_now    <= n_now;
        r_pmap   <= n_pmap;
        r_rdamp  <= n_rdamp;
        r_rmap   <= n_rmap;
        r_pout   <= n_pout;
        r_rout   <= n_rout;
        r_pband  <= n_pband;
        r_rband  <= n_rband;
        r_t      <= n_t;
        r_w      <= n_w;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_opitch <= n_opitch;
        r_oroll  <= n_oroll;
        r_oplock <= n_oplock;
        r_orlock <= n_orlock;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_pitch_out       = r_opitch;
    assign o_roll_out        = r_oroll;
    assign o_pitch_is_locked = r_oplock;
    assign o_roll_is_locked  = r_orlock;

    // A held lock never coexists with an unlock fade on either axis.
    a_lock_blend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lock[0] && r_blend[0]) && !(r_lock[1] && r_blend[1]))
        else $error("lock and fade flags both set");

    // An accepted request makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // A finished result with a free output register is presented next cycle.
    a_done_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> (o_valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

### sv/vasl_div.sv
// Restoring divider producing one quotient bit per cycle for the shared datapath.
module vasl_div
    import vasl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_dsh;
    logic [DIV_Q_W-1:0]   r_quo;
    logic                 ge;

    // The shifted divisor is compared against the partial remainder.
    assign ge = (r_rem >= r_dsh);

    // Control: busy for one cycle per quotient bit, done pulses after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract when it fits and shift the divisor down.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= DIV_NUM_W'({i_den, 16'd0});
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[DIV_Q_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
